// ----- src/b64p_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 PEM encoder package
// Shared constants, types and the base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64p_pkg;

  // Reset value of the line length register, in four-character groups.
  localparam logic [5:0] LINE_GROUPS_RESET = 6'd16;

  // Characters that are not part of the alphabet.
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Largest number of characters one input byte can cause.
  localparam int unsigned GROUP_MAX = 5;

  // Held byte and group counters.
  typedef struct packed {
    logic [1:0] held_count;
    logic [5:0] group_count;
  } cnt_t;

  // Characters caused by one input byte, sent out in index order.
  typedef struct packed {
    logic [2:0]                     n;
    logic                           msg;
    logic [GROUP_MAX-1:0][7:0]      chars;
  } grp_t;

  // Map a six-bit value to its base64 character.
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      sym = w + 8'h41;
    end else if (v < 6'd52) begin
      sym = w + 8'h47;
    end else if (v < 6'd62) begin
      sym = w - 8'd4;
    end else if (v == 6'd62) begin
      sym = 8'h2B;
    end else begin
      sym = 8'h2F;
    end
  endfunction

endpackage

// ----- src/b64p_step.sv -----
// ----------------------------------------------------------------------------
// Base64 PEM encoder step logic
// Works out the characters and the next counter values for one input byte.
// ----------------------------------------------------------------------------
module b64p_step
  import b64p_pkg::*;
(
  input  logic [7:0] byte_in,
  input  logic       last_in,
  input  logic [7:0] held0,
  input  logic [7:0] held1,
  input  cnt_t       cnt,
  input  logic [5:0] line_groups,
  output cnt_t       cnt_next,
  output logic       hold_we,
  output logic       hold_sel,
  output grp_t       grp
);

  logic [6:0] g_inc;
  logic       lf;

  // Group count after this group, and whether a line feed follows it.
  assign g_inc = {1'b0, cnt.group_count} + 7'd1;
  assign lf    = !last_in && (line_groups != 6'd0) && (g_inc >= {1'b0, line_groups});

  // Character selection and counter update.
  always_comb begin
    cnt_next       = cnt;
    hold_we        = 1'b0;
    hold_sel       = cnt.held_count[0];
    grp.n          = 3'd0;
    grp.msg        = last_in;
    grp.chars[0]   = CHAR_PAD;
    grp.chars[1]   = CHAR_PAD;
    grp.chars[2]   = CHAR_PAD;
    grp.chars[3]   = CHAR_PAD;
    grp.chars[4]   = CHAR_LF;
    if (cnt.held_count == 2'd2) begin
      // Third byte completes a full group.
      grp.chars[0] = sym(held0[7:2]);
      grp.chars[1] = sym({held0[1:0], held1[7:4]});
      grp.chars[2] = sym({held1[3:0], byte_in[7:6]});
      grp.chars[3] = sym(byte_in[5:0]);
      grp.n        = lf ? 3'd5 : 3'd4;
      cnt_next.held_count = 2'd0;
      if (!last_in && (line_groups != 6'd0) && !lf) begin
        cnt_next.group_count = g_inc[5:0];
      end else begin
        cnt_next.group_count = 6'd0;
      end
    end else if (!last_in) begin
      // Keep the byte until the group is complete.
      hold_we             = 1'b1;
      cnt_next.held_count = cnt.held_count + 2'd1;
    end else begin
      // Last byte flushes a one- or two-byte tail with padding.
      if (cnt.held_count == 2'd0) begin
        grp.chars[0] = sym(byte_in[7:2]);
        grp.chars[1] = sym({byte_in[1:0], 4'b0000});
        grp.chars[2] = CHAR_PAD;
      end else begin
        grp.chars[0] = sym(held0[7:2]);
        grp.chars[1] = sym({held0[1:0], byte_in[7:4]});
        grp.chars[2] = sym({byte_in[3:0], 2'b00});
      end
      grp.n                = 3'd4;
      cnt_next.held_count  = 2'd0;
      cnt_next.group_count = 6'd0;
    end
  end

endmodule

// ----- src/base64_pem_encoder.sv -----
// The first character of a group is offered in the cycle after the byte transfer.
// One character leaves per cycle while m_tready is high. A completed group is four or
// five characters on the single output port; a held byte causes no characters.
// A new byte is taken in the cycle that the last pending character leaves.
// Reset (rst, synchronous) clears the counters, the output queue and sets the
// line length to 16 groups.
// ----------------------------------------------------------------------------
// Base64 PEM encoder
// Streams bytes in, base64 characters out, with line feeds every line_groups groups
// (none when line_groups is zero).
module base64_pem_encoder
  import b64p_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Configuration: line_groups
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  // Input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // is_last
  // Output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tuser,   // [0] run_end
  output logic       m_tlast    // msg_end
);

  logic [5:0] line_groups;
  logic [7:0] held [2];
  cnt_t       cnt;
  cnt_t       cnt_next;
  grp_t       grp;
  grp_t       grp_next;
  logic [2:0] rem;
  logic [2:0] idx;
  logic       hold_we;
  logic       hold_sel;
  logic       s_xfer;
  logic       m_xfer;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_groups <= LINE_GROUPS_RESET;
    end else if (cfg_we) begin
      line_groups <= cfg_wdata;
    end
  end

  b64p_step u_step (
    .byte_in     (s_tdata),
    .last_in     (s_tlast),
    .held0       (held[0]),
    .held1       (held[1]),
    .cnt         (cnt),
    .line_groups (line_groups),
    .cnt_next    (cnt_next),
    .hold_we     (hold_we),
    .hold_sel    (hold_sel),
    .grp         (grp_next)
  );

  // Handshakes: a byte is taken once the last pending character is leaving.
  assign m_xfer   = m_tvalid && m_tready;
  assign s_tready = (rem == 3'd0) || ((rem == 3'd1) && m_tready);
  assign s_xfer   = s_tvalid && s_tready;

  // Counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (s_xfer) begin
      cnt <= cnt_next;
    end
  end

  // Held bytes.
  always_ff @(posedge clk) begin
    if (s_xfer && hold_we) begin
      held[hold_sel] <= s_tdata;
    end
  end

  // Group register, loaded on a transfer that causes characters.
  always_ff @(posedge clk) begin
    if (s_xfer && (grp_next.n != 3'd0)) begin
      grp <= grp_next;
    end
  end

  // Output queue position.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      idx <= 3'd0;
    end else if (s_xfer && (grp_next.n != 3'd0)) begin
      rem <= grp_next.n;
      idx <= 3'd0;
    end else if (m_xfer) begin
      rem <= rem - 3'd1;
      idx <= idx + 3'd1;
    end
  end

  // Output channel.
  assign m_tvalid = (rem != 3'd0);
  assign m_tdata  = grp.chars[idx];
  assign m_tuser  = (rem == 3'd1);
  assign m_tlast  = (rem == 3'd1) && grp.msg;

  // Checks.
  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    rem <= 3'd5)
    else $error("output queue holds more than five characters");

  a_held_range : assert property (@(posedge clk) disable iff (rst)
    cnt.held_count != 2'd3)
    else $error("more than two bytes held");

  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    s_xfer && s_tlast |=> (cnt.held_count == 2'd0) && (cnt.group_count == 6'd0))
    else $error("counters not cleared after end of message");

  a_group_load : assert property (@(posedge clk) disable iff (rst)
    s_xfer && (cnt.held_count == 2'd2) |=> (rem == 3'd4) || (rem == 3'd5))
    else $error("full group did not load four or five characters");

endmodule
